// ----- hdl/cubic_hermite_spline_eval_core_defines.svh -----
// Assertion macros used by the checker file of the spline evaluator.
`ifndef CUBIC_HERMITE_SPLINE_EVAL_CORE_DEFINES_SVH
`define CUBIC_HERMITE_SPLINE_EVAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CHSE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chse: implication check failed");

// Implication with a fixed delay in cycles, disabled while reset is high.
`define CHSE_ASSERT_DELAY(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("chse: delayed check failed");

`endif

// ----- hdl/chse_pkg.sv -----
// Shared types and constants of the cubic Hermite spline evaluator.
`default_nettype none

package chse_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int PARAM_FRAC_DEF = 16;
   localparam int AXIS_BITS      = 2;

   // Accept edge to the edge that takes the result.
   localparam int PIPE_LATENCY   = 9;

   typedef struct packed {
      logic                 vld;
      logic [AXIS_BITS-1:0] axis;
   } chse_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/chse_basis.sv -----
// Basis stages: clamp t, form t^2 and t^3, then the four Hermite weights.
`default_nettype none

module chse_basis #(
   parameter int COORD_BITS = chse_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC = chse_pkg::PARAM_FRAC_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chse_pkg::chse_ctl_type       ctl_i,
   input  logic [PARAM_FRAC:0]          param_i,
   input  logic signed [COORD_BITS-1:0] p0_i,
   input  logic signed [COORD_BITS-1:0] p1_i,
   input  logic signed [COORD_BITS-1:0] m0_i,
   input  logic signed [COORD_BITS-1:0] m1_i,
   output chse_pkg::chse_ctl_type       ctl_o,
   output logic signed [PARAM_FRAC+2:0] h00_o,
   output logic signed [PARAM_FRAC+2:0] h01_o,
   output logic signed [PARAM_FRAC+2:0] h10_o,
   output logic signed [PARAM_FRAC+2:0] h11_o,
   output logic signed [COORD_BITS-1:0] p0_o,
   output logic signed [COORD_BITS-1:0] p1_o,
   output logic signed [COORD_BITS-1:0] m0_o,
   output logic signed [COORD_BITS-1:0] m1_o
);
   import chse_pkg::*;

   localparam int TW   = PARAM_FRAC + 1;
   localparam int WW   = PARAM_FRAC + 3;
   localparam int XW   = PARAM_FRAC + 4;
   localparam int NSTG = 4;
   localparam int CW   = 4 * COORD_BITS;

   localparam logic [TW-1:0]        ONE_T  = TW'(1) << PARAM_FRAC;
   localparam logic [2*TW-1:0]      HALF_P = (2*TW)'(1) << (PARAM_FRAC - 1);
   localparam logic signed [XW-1:0] ONE_X  = XW'(1) << PARAM_FRAC;

   chse_ctl_type ctl_ff [NSTG];
   logic [CW-1:0] crd_ff [NSTG];

   logic [TW-1:0] t1_ff, t1_in;
   logic [TW-1:0] t2_ff, sq2_ff, sq2_in;
   logic [TW-1:0] t3_ff, sq3_ff, cu3_ff, cu3_in;
   logic [2*TW-1:0] sq_prod, cu_prod;
   logic signed [XW-1:0] s1x, s2x, s3x;
   logic signed [XW-1:0] h00_x, h01_x, h10_x, h11_x;
   logic signed [WW-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic signed [WW-1:0] h00_in, h01_in, h10_in, h11_in;

   // t above one clamps to one
   assign t1_in = (param_i > ONE_T) ? ONE_T : param_i;

   // rounded squares and cubes, round half up
   assign sq_prod = t1_ff * t1_ff + HALF_P;
   assign sq2_in  = sq_prod[PARAM_FRAC +: TW];
   assign cu_prod = sq2_ff * t2_ff + HALF_P;
   assign cu3_in  = cu_prod[PARAM_FRAC +: TW];

   assign s1x = $signed({3'b000, t3_ff});
   assign s2x = $signed({3'b000, sq3_ff});
   assign s3x = $signed({3'b000, cu3_ff});

   always_comb begin
      h00_x  = (s3x <<< 1) - (s2x + (s2x <<< 1)) + ONE_X;
      h01_x  = (s2x + (s2x <<< 1)) - (s3x <<< 1);
      h10_x  = s3x - (s2x <<< 1) + s1x;
      h11_x  = s3x - s2x;
      h00_in = $signed(h00_x[WW-1:0]);
      h01_in = $signed(h01_x[WW-1:0]);
      h10_in = $signed(h10_x[WW-1:0]);
      h11_in = $signed(h11_x[WW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_i;
         for (int i = 1; i < NSTG; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      crd_ff[0] <= {p0_i, p1_i, m0_i, m1_i};
      for (int i = 1; i < NSTG; i++) begin
         crd_ff[i] <= crd_ff[i-1];
      end
      t1_ff  <= t1_in;
      t2_ff  <= t1_ff;
      sq2_ff <= sq2_in;
      t3_ff  <= t2_ff;
      sq3_ff <= sq2_ff;
      cu3_ff <= cu3_in;
      h00_ff <= h00_in;
      h01_ff <= h01_in;
      h10_ff <= h10_in;
      h11_ff <= h11_in;
   end

   assign ctl_o = ctl_ff[NSTG-1];
   assign h00_o = h00_ff;
   assign h01_o = h01_ff;
   assign h10_o = h10_ff;
   assign h11_o = h11_ff;
   assign p0_o  = $signed(crd_ff[NSTG-1][4*COORD_BITS-1:3*COORD_BITS]);
   assign p1_o  = $signed(crd_ff[NSTG-1][3*COORD_BITS-1:2*COORD_BITS]);
   assign m0_o  = $signed(crd_ff[NSTG-1][2*COORD_BITS-1:COORD_BITS]);
   assign m1_o  = $signed(crd_ff[NSTG-1][COORD_BITS-1:0]);

endmodule

`default_nettype wire

// ----- hdl/chse_mac.sv -----
// Weighted products in split halves, recombined, then summed in pairs.
`default_nettype none

module chse_mac #(
   parameter int COORD_BITS = chse_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC = chse_pkg::PARAM_FRAC_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chse_pkg::chse_ctl_type       ctl_i,
   input  logic signed [PARAM_FRAC+2:0] h00_i,
   input  logic signed [PARAM_FRAC+2:0] h01_i,
   input  logic signed [PARAM_FRAC+2:0] h10_i,
   input  logic signed [PARAM_FRAC+2:0] h11_i,
   input  logic signed [COORD_BITS-1:0] p0_i,
   input  logic signed [COORD_BITS-1:0] p1_i,
   input  logic signed [COORD_BITS-1:0] m0_i,
   input  logic signed [COORD_BITS-1:0] m1_i,
   output chse_pkg::chse_ctl_type       ctl_o,
   output logic signed [COORD_BITS+PARAM_FRAC+3:0] sum_a_o,
   output logic signed [COORD_BITS+PARAM_FRAC+3:0] sum_b_o
);
   import chse_pkg::*;

   localparam int WW   = PARAM_FRAC + 3;
   localparam int LO   = COORD_BITS / 2;
   localparam int HI   = COORD_BITS - LO;
   localparam int LPW  = WW + LO + 1;
   localparam int HPW  = WW + HI;
   localparam int PW   = COORD_BITS + WW;
   localparam int NT   = 4;
   localparam int NSTG = 3;

   logic signed [WW-1:0]         wgt [NT];
   logic signed [COORD_BITS-1:0] crd [NT];

   logic signed [LPW-1:0] lo_ff [NT];
   logic signed [LPW-1:0] lo_in [NT];
   logic signed [HPW-1:0] hi_ff [NT];
   logic signed [HPW-1:0] hi_in [NT];
   logic signed [PW-1:0]  term_ff [NT];
   logic signed [PW-1:0]  term_in [NT];
   logic signed [PW:0]    sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;

   chse_ctl_type ctl_ff [NSTG];

   assign wgt[0] = h00_i;
   assign wgt[1] = h01_i;
   assign wgt[2] = h10_i;
   assign wgt[3] = h11_i;
   assign crd[0] = p0_i;
   assign crd[1] = p1_i;
   assign crd[2] = m0_i;
   assign crd[3] = m1_i;

   // low half unsigned, high half signed
   always_comb begin
      for (int k = 0; k < NT; k++) begin
         lo_in[k]   = wgt[k] * $signed({1'b0, crd[k][LO-1:0]});
         hi_in[k]   = wgt[k] * $signed(crd[k][COORD_BITS-1:LO]);
         term_in[k] = $signed({hi_ff[k], {LO{1'b0}}}) + PW'(lo_ff[k]);
      end
      sum_a_in = (PW+1)'(term_ff[0]) + (PW+1)'(term_ff[1]);
      sum_b_in = (PW+1)'(term_ff[2]) + (PW+1)'(term_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_i;
         for (int i = 1; i < NSTG; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NT; k++) begin
         lo_ff[k]   <= lo_in[k];
         hi_ff[k]   <= hi_in[k];
         term_ff[k] <= term_in[k];
      end
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
   end

   assign ctl_o   = ctl_ff[NSTG-1];
   assign sum_a_o = sum_a_ff;
   assign sum_b_o = sum_b_ff;

endmodule

`default_nettype wire

// ----- hdl/chse_round.sv -----
// Final add with round half up, scale back, saturate and drive the result.
`default_nettype none

module chse_round #(
   parameter int COORD_BITS = chse_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC = chse_pkg::PARAM_FRAC_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  chse_pkg::chse_ctl_type                  ctl_i,
   input  logic signed [COORD_BITS+PARAM_FRAC+3:0] sum_a_i,
   input  logic signed [COORD_BITS+PARAM_FRAC+3:0] sum_b_i,
   output logic                                    strobe_o,
   output logic [chse_pkg::AXIS_BITS-1:0]          axis_o,
   output logic signed [COORD_BITS-1:0]            value_o,
   output logic                                    clipped_o
);
   import chse_pkg::*;

   localparam int SW = COORD_BITS + PARAM_FRAC + 4;
   localparam int AW = SW + 1;
   localparam int RW = AW - PARAM_FRAC;

   localparam logic signed [AW-1:0] HALF = AW'(1) << (PARAM_FRAC - 1);
   localparam logic signed [RW-1:0] CMAX = {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] CMIN = {{(RW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   chse_ctl_type ctl_ff;
   logic signed [AW-1:0] acc;
   logic signed [RW-1:0] res_ff, res_in;

   logic                         strobe_ff;
   logic [AXIS_BITS-1:0]         axis_ff;
   logic signed [COORD_BITS-1:0] value_ff, value_in;
   logic                         clipped_ff, clipped_in;

   // arithmetic shift gives floor, so ties go toward plus infinity
   assign acc    = AW'(sum_a_i) + AW'(sum_b_i) + HALF;
   assign res_in = $signed(acc[AW-1:PARAM_FRAC]);

   always_comb begin
      if (res_ff > CMAX) begin
         value_in   = CMAX[COORD_BITS-1:0];
         clipped_in = 1'b1;
      end else if (res_ff < CMIN) begin
         value_in   = CMIN[COORD_BITS-1:0];
         clipped_in = 1'b1;
      end else begin
         value_in   = res_ff[COORD_BITS-1:0];
         clipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl_ff    <= ctl_i;
         strobe_ff <= ctl_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      axis_ff    <= ctl_ff.axis;
      value_ff   <= value_in;
      clipped_ff <= clipped_in;
   end

   assign strobe_o  = strobe_ff;
   assign axis_o    = axis_ff;
   assign value_o   = value_ff;
   assign clipped_o = clipped_ff;

endmodule

`default_nettype wire

// ----- hdl/cubic_hermite_spline_eval_core.sv -----
// Top level of the pipelined cubic Hermite spline evaluator, one coordinate per transaction.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   request  | start, busy        | req_axis_tag, req_start_point, req_end_point,
//            |                    | req_start_slope, req_end_slope, req_curve_param
//   response | rsp_strobe         | rsp_axis_out, rsp_curve_value, rsp_clipped
//
// A transaction is taken at every edge with start high and busy low, one per cycle.
// From accept to the edge that takes the result, a transaction passes the nine
//   register stages: clamp, t^2, t^3, weights, split products, terms, pair sums,
//   round, saturate.
// busy is high only during reset and in the cycle after; the pipeline never stalls.
// rsp_strobe marks a result for one cycle; the receiver cannot hold it off.
// Synchronous reset clears the valid bits; no transaction survives it.
`default_nettype none

module cubic_hermite_spline_eval_core #(
   parameter int COORD_BITS = chse_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC = chse_pkg::PARAM_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [chse_pkg::AXIS_BITS-1:0]      req_axis_tag,
   input  logic signed [COORD_BITS-1:0]        req_start_point,
   input  logic signed [COORD_BITS-1:0]        req_end_point,
   input  logic signed [COORD_BITS-1:0]        req_start_slope,
   input  logic signed [COORD_BITS-1:0]        req_end_slope,
   input  logic [PARAM_FRAC:0]                 req_curve_param,
   // response channel
   output logic                                rsp_strobe,
   output logic [chse_pkg::AXIS_BITS-1:0]      rsp_axis_out,
   output logic signed [COORD_BITS-1:0]        rsp_curve_value,
   output logic                                rsp_clipped
);
   import chse_pkg::*;

   localparam int WW = PARAM_FRAC + 3;
   localparam int SW = COORD_BITS + PARAM_FRAC + 4;

   logic busy_ff, busy_in;

   chse_ctl_type req_ctl, bas_ctl, mac_ctl;

   logic signed [WW-1:0]         h00, h01, h10, h11;
   logic signed [COORD_BITS-1:0] p0, p1, m0, m1;
   logic signed [SW-1:0]         sum_a, sum_b;

   // busy covers reset so nothing slips in while the valid bits clear
   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy = busy_ff;

   // valid bit of the entering transaction
   assign req_ctl.vld  = start & ~busy_ff;
   assign req_ctl.axis = req_axis_tag;

   // stages 1-4: t clamp, t^2, t^3, Hermite weights
   chse_basis #(
      .COORD_BITS (COORD_BITS),
      .PARAM_FRAC (PARAM_FRAC)
   ) u_basis (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (req_ctl),
      .param_i (req_curve_param),
      .p0_i    (req_start_point),
      .p1_i    (req_end_point),
      .m0_i    (req_start_slope),
      .m1_i    (req_end_slope),
      .ctl_o   (bas_ctl),
      .h00_o   (h00),
      .h01_o   (h01),
      .h10_o   (h10),
      .h11_o   (h11),
      .p0_o    (p0),
      .p1_o    (p1),
      .m0_o    (m0),
      .m1_o    (m1)
   );

   // stages 5-7: half-width products, recombined terms, pair sums
   chse_mac #(
      .COORD_BITS (COORD_BITS),
      .PARAM_FRAC (PARAM_FRAC)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (bas_ctl),
      .h00_i   (h00),
      .h01_i   (h01),
      .h10_i   (h10),
      .h11_i   (h11),
      .p0_i    (p0),
      .p1_i    (p1),
      .m0_i    (m0),
      .m1_i    (m1),
      .ctl_o   (mac_ctl),
      .sum_a_o (sum_a),
      .sum_b_o (sum_b)
   );

   // stages 8-9: final add with rounding, saturation, response registers
   chse_round #(
      .COORD_BITS (COORD_BITS),
      .PARAM_FRAC (PARAM_FRAC)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (mac_ctl),
      .sum_a_i   (sum_a),
      .sum_b_i   (sum_b),
      .strobe_o  (rsp_strobe),
      .axis_o    (rsp_axis_out),
      .value_o   (rsp_curve_value),
      .clipped_o (rsp_clipped)
   );

endmodule

`default_nettype wire

// ----- hdl/chse_checker.sv -----
// Port-level checker for the spline evaluator, bound to the top level.
`default_nettype none
`include "cubic_hermite_spline_eval_core_defines.svh"

module chse_checker #(
   parameter int COORD_BITS = chse_pkg::COORD_BITS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [chse_pkg::AXIS_BITS-1:0] req_axis_tag,
   input logic                           rsp_strobe,
   input logic [chse_pkg::AXIS_BITS-1:0] rsp_axis_out,
   input logic signed [COORD_BITS-1:0]   rsp_curve_value,
   input logic                           rsp_clipped
);
   import chse_pkg::*;

   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // busy only follows reset
   `CHSE_ASSERT_IMPLY(a_busy_low, !$past(reset), !busy)

   // every accepted transaction returns after the fixed latency
   `CHSE_ASSERT_DELAY(a_latency, start && !busy, PIPE_LATENCY, rsp_strobe)

   // axis tag follows its transaction through the pipeline
   `CHSE_ASSERT_IMPLY(a_axis, rsp_strobe, rsp_axis_out == $past(req_axis_tag, PIPE_LATENCY))

   // a clipped result sits on a range limit
   `CHSE_ASSERT_IMPLY(a_clip, rsp_strobe && rsp_clipped, rsp_curve_value == CMAX || rsp_curve_value == CMIN)

endmodule

bind cubic_hermite_spline_eval_core chse_checker #(
   .COORD_BITS (COORD_BITS)
) u_chse_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_axis_tag    (req_axis_tag),
   .rsp_strobe      (rsp_strobe),
   .rsp_axis_out    (rsp_axis_out),
   .rsp_curve_value (rsp_curve_value),
   .rsp_clipped     (rsp_clipped)
);

`default_nettype wire
